// ===== hw/rtl/gsnm_pkg.sv =====
`default_nettype none

package gsnm_pkg;

    localparam int ORDER     = 3;
    localparam int HALF_SPAN = ORDER / 2;
    localparam int SPAN      = 2 * HALF_SPAN + 1;
    localparam int CNT_W     = (SPAN > 1) ? $clog2(SPAN) : 1;

    // divider: 34-bit magnitude, two quotient bits per cycle
    localparam int MAG_W          = 34;
    localparam int DIV_BITS       = 2;
    localparam int DIV_CYCLES     = MAG_W / DIV_BITS;
    localparam int DIV_CNT_W      = $clog2(DIV_CYCLES);

    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_INDEX_W    = 3;
    localparam int CFG_DATA_W     = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MIN_CORNER_X  = 3'd0,
        CFG_MIN_CORNER_Y  = 3'd1,
        CFG_MIN_CORNER_Z  = 3'd2,
        CFG_SPACING_X     = 3'd3,
        CFG_SPACING_Y     = 3'd4,
        CFG_SPACING_Z     = 3'd5,
        CFG_GRID_POINTS_Y = 3'd6,
        CFG_GRID_POINTS_Z = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } point_t;

    typedef struct packed {
        logic        [31:0] node_index;
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
        logic signed [31:0] offset_z;
        logic               last_node;
    } result_t;

    typedef struct packed {
        logic signed [31:0] min_corner_x;
        logic signed [31:0] min_corner_y;
        logic signed [31:0] min_corner_z;
        logic        [30:0] spacing_x;
        logic        [30:0] spacing_y;
        logic        [30:0] spacing_z;
        logic        [15:0] grid_points_y;
        logic        [15:0] grid_points_z;
    } cfg_t;

    // one stencil command from front to back
    typedef struct packed {
        logic [31:0] idx0;
        logic [31:0] step_x;
        logic [31:0] step_y;
        logic [31:0] off0_x;
        logic [31:0] off0_y;
        logic [31:0] off0_z;
        logic [31:0] sp_x;
        logic [31:0] sp_y;
        logic [31:0] sp_z;
    } cmd_t;

    // zero spacing acts as the smallest step
    function automatic logic [31:0] eff_spacing(input logic [30:0] s);
        logic [31:0] r;
        if (s == 31'd0)
        begin
            r = 32'd1;
        end
        else
        begin
            r = {1'b0, s};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/gsnm_queue.sv =====
`default_nettype none

module gsnm_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire gsnm_pkg::cmd_t wdata,
    input  wire logic          pop,
    output logic               empty,
    output gsnm_pkg::cmd_t     rdata
);
    import gsnm_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/gsnm_front.sv =====
`default_nettype none

module gsnm_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire gsnm_pkg::cfg_t   cfg,
    input  wire logic             push,
    output logic                  full,
    input  wire gsnm_pkg::point_t point,
    output logic                  q_push,
    input  wire logic             q_full,
    output gsnm_pkg::cmd_t        q_data
);
    import gsnm_pkg::*;

    typedef enum logic [6:0] {
        F_IDLE = 7'b0000001,
        F_PREP = 7'b0000010,
        F_DIV  = 7'b0000100,
        F_FIX  = 7'b0001000,
        F_MUL1 = 7'b0010000,
        F_MUL2 = 7'b0100000,
        F_PUSH = 7'b1000000
    } front_state_t;

    localparam logic [31:0] HALF_W  = 32'(HALF_SPAN);
    localparam logic [31:0] ADD_POS = 32'd0 - HALF_W;
    localparam logic [31:0] ADD_NEG = 32'd1 - HALF_W;

    front_state_t         state_reg, state_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    logic [31:0]      rel_reg  [3];
    logic [31:0]      rem_reg  [3];
    logic [MAG_W-1:0] mag_reg  [3];
    logic             neg_reg  [3];
    logic [31:0]      n0_reg   [3];
    logic [31:0]      base_reg [3];
    logic [31:0]      off0_reg [3];
    logic [31:0]      prod_x_reg;
    logic [31:0]      gyz_reg;
    logic [31:0]      t_reg;

    logic [31:0]      coord    [3];
    logic [31:0]      minc     [3];
    logic [31:0]      spe      [3];
    logic [31:0]      rem_step [3];
    logic [MAG_W-1:0] mag_step [3];
    logic [MAG_W-1:0] num      [3];
    logic [31:0]      gy_w, gz_w;

    assign coord[0] = point.point_x;
    assign coord[1] = point.point_y;
    assign coord[2] = point.point_z;
    assign minc[0]  = cfg.min_corner_x;
    assign minc[1]  = cfg.min_corner_y;
    assign minc[2]  = cfg.min_corner_z;
    assign spe[0]   = eff_spacing(cfg.spacing_x);
    assign spe[1]   = eff_spacing(cfg.spacing_y);
    assign spe[2]   = eff_spacing(cfg.spacing_z);
    assign gy_w     = {16'b0, cfg.grid_points_y};
    assign gz_w     = {16'b0, cfg.grid_points_z};

    assign full = (state_reg != F_IDLE);

    // 2*rel + s, then restoring division by 2*s, two bits a cycle
    always_comb
    begin
        logic [32:0]      sh;
        logic [31:0]      r;
        logic [MAG_W-1:0] m;
        logic [32:0]      d;
        for (int a = 0; a < 3; a++)
        begin
            num[a] = {rel_reg[a][31], rel_reg[a], 1'b0} + {2'b00, spe[a]};
            d = {1'b0, spe[a][30:0], 1'b0};
            r = rem_reg[a];
            m = mag_reg[a];
            for (int k = 0; k < DIV_BITS; k++)
            begin
                sh = {r, m[MAG_W-1]};
                m  = {m[MAG_W-2:0], 1'b0};
                if (sh >= d)
                begin
                    sh   = sh - d;
                    m[0] = 1'b1;
                end
                r = sh[31:0];
            end
            rem_step[a] = r;
            mag_step[a] = m;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:  if (push) state_next = F_PREP;
            F_PREP:  state_next = F_DIV;
            F_DIV:   if (div_cnt_reg == DIV_CNT_W'(DIV_CYCLES - 1)) state_next = F_FIX;
            F_FIX:   state_next = F_MUL1;
            F_MUL1:  state_next = F_MUL2;
            F_MUL2:  state_next = F_PUSH;
            F_PUSH:  if (!q_full) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= F_IDLE;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == F_DIV)
            begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
            else
            begin
                div_cnt_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int a = 0; a < 3; a++)
        begin
            if (state_reg == F_IDLE && push)
            begin
                rel_reg[a] <= coord[a] - minc[a];
            end
            if (state_reg == F_PREP)
            begin
                neg_reg[a] <= num[a][MAG_W-1];
                mag_reg[a] <= num[a][MAG_W-1] ? (MAG_W'(0) - num[a]) : num[a];
                rem_reg[a] <= '0;
            end
            if (state_reg == F_DIV)
            begin
                mag_reg[a] <= mag_step[a];
                rem_reg[a] <= rem_step[a];
            end
            if (state_reg == F_FIX)
            begin
                n0_reg[a] <= neg_reg[a] ? (~mag_reg[a][31:0] + ADD_NEG)
                                        : (mag_reg[a][31:0] + ADD_POS);
            end
            if (state_reg == F_MUL1)
            begin
                base_reg[a] <= n0_reg[a] * spe[a];
            end
            if (state_reg == F_MUL2)
            begin
                off0_reg[a] <= base_reg[a] - rel_reg[a];
            end
        end
        if (state_reg == F_MUL1)
        begin
            prod_x_reg <= n0_reg[0] * gy_w;
            gyz_reg    <= gy_w * gz_w;
        end
        if (state_reg == F_MUL2)
        begin
            t_reg <= (prod_x_reg + n0_reg[1]) * gz_w;
        end
    end

    assign q_push        = (state_reg == F_PUSH) && !q_full;
    assign q_data.idx0   = t_reg + n0_reg[2];
    assign q_data.step_x = gyz_reg;
    assign q_data.step_y = gz_w;
    assign q_data.off0_x = off0_reg[0];
    assign q_data.off0_y = off0_reg[1];
    assign q_data.off0_z = off0_reg[2];
    assign q_data.sp_x   = spe[0];
    assign q_data.sp_y   = spe[1];
    assign q_data.sp_z   = spe[2];

endmodule

`default_nettype wire

// ===== hw/rtl/gsnm_back.sv =====
`default_nettype none

module gsnm_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_empty,
    input  wire gsnm_pkg::cmd_t q_data,
    output logic                q_pop,
    output logic                empty,
    input  wire logic           pop,
    output gsnm_pkg::result_t   result
);
    import gsnm_pkg::*;

    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(SPAN - 1);

    logic             active_reg;
    cmd_t             cmd_reg;
    logic [CNT_W-1:0] ix_reg, iy_reg, iz_reg;
    logic [31:0]      idx_reg, idx_x_reg, idx_y_reg;
    logic [31:0]      offx_reg, offy_reg, offz_reg;
    logic             valid_reg;
    result_t          res_reg;

    cmd_t             src;
    logic [CNT_W-1:0] ix_cur, iy_cur, iz_cur;
    logic [31:0]      idx_cur, idx_x_cur, idx_y_cur;
    logic [31:0]      offx_cur, offy_cur, offz_cur;
    logic [CNT_W-1:0] ix_next, iy_next, iz_next;
    logic [31:0]      idx_next, idx_x_next, idx_y_next;
    logic [31:0]      offx_next, offy_next, offz_next;
    logic             last, have, advance, fire;

    // a new command starts at its first node straight from the queue
    always_comb
    begin
        if (active_reg)
        begin
            src       = cmd_reg;
            ix_cur    = ix_reg;
            iy_cur    = iy_reg;
            iz_cur    = iz_reg;
            idx_cur   = idx_reg;
            idx_x_cur = idx_x_reg;
            idx_y_cur = idx_y_reg;
            offx_cur  = offx_reg;
            offy_cur  = offy_reg;
            offz_cur  = offz_reg;
        end
        else
        begin
            src       = q_data;
            ix_cur    = '0;
            iy_cur    = '0;
            iz_cur    = '0;
            idx_cur   = q_data.idx0;
            idx_x_cur = q_data.idx0;
            idx_y_cur = q_data.idx0;
            offx_cur  = q_data.off0_x;
            offy_cur  = q_data.off0_y;
            offz_cur  = q_data.off0_z;
        end
    end

    assign last = (ix_cur == CNT_END) && (iy_cur == CNT_END) && (iz_cur == CNT_END);

    always_comb
    begin
        ix_next    = ix_cur;
        iy_next    = iy_cur;
        iz_next    = iz_cur;
        idx_next   = idx_cur;
        idx_x_next = idx_x_cur;
        idx_y_next = idx_y_cur;
        offx_next  = offx_cur;
        offy_next  = offy_cur;
        offz_next  = offz_cur;
        if (iz_cur != CNT_END)
        begin
            iz_next   = iz_cur + 1'b1;
            idx_next  = idx_cur + 32'd1;
            offz_next = offz_cur + src.sp_z;
        end
        else if (iy_cur != CNT_END)
        begin
            iz_next    = '0;
            offz_next  = src.off0_z;
            iy_next    = iy_cur + 1'b1;
            offy_next  = offy_cur + src.sp_y;
            idx_y_next = idx_y_cur + src.step_y;
            idx_next   = idx_y_cur + src.step_y;
        end
        else
        begin
            iz_next    = '0;
            offz_next  = src.off0_z;
            iy_next    = '0;
            offy_next  = src.off0_y;
            ix_next    = ix_cur + 1'b1;
            offx_next  = offx_cur + src.sp_x;
            idx_x_next = idx_x_cur + src.step_x;
            idx_y_next = idx_x_cur + src.step_x;
            idx_next   = idx_x_cur + src.step_x;
        end
    end

    assign have    = active_reg || !q_empty;
    assign advance = !valid_reg || pop;
    assign fire    = advance && have;
    assign q_pop   = advance && !active_reg && !q_empty;
    assign empty   = !valid_reg;
    assign result  = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                valid_reg <= have;
            end
            if (fire)
            begin
                active_reg <= !last;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg.node_index <= idx_cur;
            res_reg.offset_x   <= offx_cur;
            res_reg.offset_y   <= offy_cur;
            res_reg.offset_z   <= offz_cur;
            res_reg.last_node  <= last;
            cmd_reg            <= src;
            ix_reg             <= ix_next;
            iy_reg             <= iy_next;
            iz_reg             <= iz_next;
            idx_reg            <= idx_next;
            idx_x_reg          <= idx_x_next;
            idx_y_reg          <= idx_y_next;
            offx_reg           <= offx_next;
            offy_reg           <= offy_next;
            offz_reg           <= offz_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/grid_stencil_node_mapper.sv =====
`default_nettype none

// Maps one Q16.16 point to its 3x3x3 grid stencil and delivers 27 results per point,
// x outermost and z innermost, last_node high on the final one. The back end emits one
// result per cycle while the consumer keeps popping. The front end divides with two
// quotient bits a cycle on all three axes at once, steps through its prep, divide, fix,
// multiply and push states, and works on the next point while the back end is still
// emitting; a two-entry command queue sits between them. Configuration must be written
// only while the block is idle; the user must ensure this, as the block does not enforce it.
module grid_stencil_node_mapper (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    cfg_we,
    input  wire logic [gsnm_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  wire logic [gsnm_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  wire logic                                    push,
    output logic                                         full,
    input  wire gsnm_pkg::point_t                        point,
    output logic                                         empty,
    input  wire logic                                    pop,
    output gsnm_pkg::result_t                            result
);
    import gsnm_pkg::*;

    cfg_t cfg_reg;
    logic q_push, q_full, q_pop, q_empty;
    cmd_t q_wdata, q_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_corner_x  <= '0;
            cfg_reg.min_corner_y  <= '0;
            cfg_reg.min_corner_z  <= '0;
            cfg_reg.spacing_x     <= 31'd65536;
            cfg_reg.spacing_y     <= 31'd65536;
            cfg_reg.spacing_z     <= 31'd65536;
            cfg_reg.grid_points_y <= 16'd1;
            cfg_reg.grid_points_z <= 16'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_MIN_CORNER_X:  cfg_reg.min_corner_x  <= cfg_data;
                CFG_MIN_CORNER_Y:  cfg_reg.min_corner_y  <= cfg_data;
                CFG_MIN_CORNER_Z:  cfg_reg.min_corner_z  <= cfg_data;
                CFG_SPACING_X:     cfg_reg.spacing_x     <= cfg_data[30:0];
                CFG_SPACING_Y:     cfg_reg.spacing_y     <= cfg_data[30:0];
                CFG_SPACING_Z:     cfg_reg.spacing_z     <= cfg_data[30:0];
                CFG_GRID_POINTS_Y: cfg_reg.grid_points_y <= cfg_data[15:0];
                CFG_GRID_POINTS_Z: cfg_reg.grid_points_z <= cfg_data[15:0];
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    gsnm_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .push   (push),
        .full   (full),
        .point  (point),
        .q_push (q_push),
        .q_full (q_full),
        .q_data (q_wdata)
    );

    gsnm_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .full  (q_full),
        .wdata (q_wdata),
        .pop   (q_pop),
        .empty (q_empty),
        .rdata (q_rdata)
    );

    gsnm_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_rdata),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

`default_nettype wire
